// ----- sv/size_budget_lru_evictor_top_assert.svh -----
`ifndef SIZE_BUDGET_LRU_EVICTOR_TOP_ASSERT_SVH
`define SIZE_BUDGET_LRU_EVICTOR_TOP_ASSERT_SVH

// same-cycle implication
`define SBLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sble_pkg.sv -----
package sble_pkg;

    localparam int DEF_ENTRIES   = 32;
    localparam int DEF_SIZE_BITS = 32;
    localparam int SLOT_W        = 6;
    localparam logic [SLOT_W-1:0] NONE_SLOT = 6'd63;

    localparam logic [31:0] RST_FREE_TARGET  = 32'd16777216;
    localparam logic [31:0] RST_HIGH_LIMIT   = 32'd16777216;
    localparam logic [15:0] RST_CLEAN_PERIOD = 16'd60;
    localparam logic [32:0] RECIP3           = 33'h0AAAAAAAB;
    localparam int          RECIP3_SHIFT     = 33;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_REL   = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_FREE_TARGET  = 2'd0,
        REG_HIGH_LIMIT   = 2'd1,
        REG_CLEAN_PERIOD = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_RD,
        ST_SET,
        ST_PUSH1,
        ST_PUSH2,
        ST_CHK,
        ST_REL,
        ST_EV_RD,
        ST_EV_UPD,
        ST_EV_END,
        ST_EM_RD,
        ST_EM_WAIT,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  entry;
        logic [31:0] new_size;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [4:0]  victim;
        logic [31:0] freed_bytes;
        logic [31:0] total_bytes;
        logic        released;
        logic        last;
    } t_out;

endpackage

// ----- sv/sble_ram.sv -----
module sble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/size_budget_lru_evictor_top.sv -----
// LRU evictor with a byte budget. Links and charges of the slots live in synchronous
// RAMs; a sequencer reads, updates and writes them back, one item at a time. A set size
// pushes the slot as newest when the slot is relinked or newly listed; a zero size ends
// a set size, and an out-of-range slot ends a set size or release, with no change made.
// An eviction walk reads the link and charge of each evicted slot, then unlinks it, and
// then closes the walk; it stops short of its target on an empty list, a protected slot
// or the slot limit, and always so on a flush. Each eviction report is then replayed from
// the victim log ahead of the summary. Output stalls hold the report and summary states.
// The input is stalled while an item is in progress.
module size_budget_lru_evictor_top #(
    parameter int ENTRIES   = sble_pkg::DEF_ENTRIES,
    parameter int SIZE_BITS = sble_pkg::DEF_SIZE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sble_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sble_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import sble_pkg::*;

    localparam int AW    = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SB    = SIZE_BITS;
    localparam int CW    = (SIZE_BITS > 32) ? SIZE_BITS : 32;
    localparam int LW    = SLOT_W + SIZE_BITS;
    localparam logic [CW:0] SMAX_W = ((CW + 1)'(1) << SIZE_BITS) - (CW + 1)'(1);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_entry, n_entry;
    logic [SB-1:0]     r_size, n_size;
    logic [SB-1:0]     r_old, n_old;
    logic [SB-1:0]     r_total, n_total;
    logic [SB-1:0]     r_freed, n_freed;
    logic [CW-1:0]     r_target, n_target;
    logic [SLOT_W-1:0] r_protect, n_protect;
    logic              r_all, n_all;
    logic              r_rel, n_rel;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic [SLOT_W-1:0] r_newest, n_newest;
    logic [ENTRIES-1:0] r_in_list, n_in_list;
    logic [31:0]       r_tick, n_tick;
    logic [31:0]       r_next, n_next;
    logic [31:0]       r_ft, r_hl, r_hl3;
    logic [15:0]       r_period;
    logic              r_ov, n_ov;
    t_out              r_out, n_out;

    logic              older_we, newer_we, charge_we, log_we;
    logic [AW-1:0]     older_waddr, newer_waddr, charge_waddr, log_waddr;
    logic [SLOT_W-1:0] older_wdata, newer_wdata;
    logic [SB-1:0]     charge_wdata;
    logic [LW-1:0]     log_wdata, log_rdata;
    logic [AW-1:0]     slot_raddr;
    logic [SLOT_W-1:0] older_rdata, newer_rdata;
    logic [SB-1:0]     charge_rdata;

    logic              in_take, out_free, cfg_wr;
    logic [31:0]       tick_inc;
    logic              tick_due, over_ft;
    logic [CW-1:0]     ft_diff;
    logic [CW:0]       ft_dbl;
    logic [CW-1:0]     tick_target;
    logic              entry_in_list, entry_ok, set_relink;
    logic [SB-1:0]     set_old, set_sub, set_total, rel_total, ev_total;
    logic [SB:0]       set_sum, ev_sum;
    logic [SB-1:0]     ev_freed;
    logic              ev_stop, ev_done, chk_evict;

    sble_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_older (
        .i_clk, .i_we(older_we), .i_waddr(older_waddr), .i_wdata(older_wdata),
        .i_raddr(slot_raddr), .o_rdata(older_rdata));
    sble_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_newer (
        .i_clk, .i_we(newer_we), .i_waddr(newer_waddr), .i_wdata(newer_wdata),
        .i_raddr(slot_raddr), .o_rdata(newer_rdata));
    sble_ram #(.WIDTH(SB), .DEPTH(ENTRIES)) u_charge (
        .i_clk, .i_we(charge_we), .i_waddr(charge_waddr), .i_wdata(charge_wdata),
        .i_raddr(slot_raddr), .o_rdata(charge_rdata));
    sble_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_log (
        .i_clk, .i_we(log_we), .i_waddr(log_waddr), .i_wdata(log_wdata),
        .i_raddr(r_idx[AW-1:0]), .o_rdata(log_rdata));

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_FREE_TARGET:  prdata = r_ft;
            REG_HIGH_LIMIT:   prdata = r_hl;
            REG_CLEAN_PERIOD: prdata = {16'd0, r_period};
            default:          prdata = 32'd0;
        endcase
    end

    assign slot_raddr = (r_state == ST_EV_RD) ? r_oldest[AW-1:0] : r_entry[AW-1:0];

    assign tick_inc    = r_tick + 32'd1;
    assign tick_due    = tick_inc >= r_next;
    assign over_ft     = CW'(r_total) > CW'(r_ft);
    assign ft_diff     = CW'(r_total) - CW'(r_ft);
    assign ft_dbl      = {ft_diff, 1'b0};
    assign tick_target = (ft_dbl > SMAX_W) ? CW'(SMAX_W) : CW'(ft_dbl);

    assign entry_ok      = r_entry < SLOT_W'(ENTRIES);
    assign entry_in_list = r_in_list[r_entry[AW-1:0]];
    assign set_relink    = entry_in_list && (r_newest != r_entry);
    assign set_old       = entry_in_list ? charge_rdata : '0;
    assign set_sub       = (r_total >= set_old) ? r_total - set_old : '0;
    assign set_sum       = {1'b0, set_sub} + {1'b0, r_size};
    assign set_total     = set_sum[SB] ? '1 : set_sum[SB-1:0];
    assign rel_total     = (r_total >= charge_rdata) ? r_total - charge_rdata : '0;
    assign ev_sum        = {1'b0, r_freed} + {1'b0, charge_rdata};
    assign ev_freed      = ev_sum[SB] ? '1 : ev_sum[SB-1:0];
    assign ev_total      = (r_total > r_freed) ? r_total - r_freed : '0;
    assign ev_stop       = (r_oldest == NONE_SLOT) || (r_cnt == CNT_W'(ENTRIES))
                           || (r_oldest == r_protect);
    assign ev_done       = !r_all && (CW'(ev_freed) >= r_target);
    assign chk_evict     = (r_size > r_old) && (r_hl != 32'd0) && (CW'(r_total) > CW'(r_hl));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    case (t_cmd'(i_in_data.cmd))
                        CMD_TICK:  n_state = ST_TICK;
                        CMD_SET:   n_state = ST_RD;
                        CMD_REL:   n_state = ST_RD;
                        CMD_FLUSH: n_state = ST_EV_RD;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK:    n_state = (tick_due && over_ft) ? ST_EV_RD : ST_SUM;
            ST_RD: begin
                if (!entry_ok || (r_cmd == CMD_SET && r_size == '0)) begin
                    n_state = ST_SUM;
                end else begin
                    n_state = (r_cmd == CMD_SET) ? ST_SET : ST_REL;
                end
            end
            ST_SET:     n_state = (!entry_in_list || set_relink) ? ST_PUSH1 : ST_CHK;
            ST_PUSH1:   n_state = ST_PUSH2;
            ST_PUSH2:   n_state = ST_CHK;
            ST_CHK:     n_state = chk_evict ? ST_EV_RD : ST_SUM;
            ST_REL:     n_state = ST_SUM;
            ST_EV_RD:   n_state = ev_stop ? ST_EV_END : ST_EV_UPD;
            ST_EV_UPD:  n_state = ev_done ? ST_EV_END : ST_EV_RD;
            ST_EV_END:  n_state = (r_cnt != '0) ? ST_EM_RD : ST_SUM;
            ST_EM_RD:   n_state = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (out_free) begin
                    n_state = ((r_idx + CNT_W'(1)) == r_cnt) ? ST_SUM : ST_EM_RD;
                end
            end
            ST_SUM:     n_state = out_free ? ST_IDLE : ST_SUM;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_entry   = r_entry;
        n_size    = r_size;
        n_old     = r_old;
        n_total   = r_total;
        n_freed   = r_freed;
        n_target  = r_target;
        n_protect = r_protect;
        n_all     = r_all;
        n_rel     = r_rel;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_oldest  = r_oldest;
        n_newest  = r_newest;
        n_in_list = r_in_list;
        n_tick    = r_tick;
        n_next    = r_next;
        n_ov      = r_ov && i_out_stall;
        n_out     = r_out;

        older_we     = 1'b0;
        older_waddr  = r_entry[AW-1:0];
        older_wdata  = NONE_SLOT;
        newer_we     = 1'b0;
        newer_waddr  = r_entry[AW-1:0];
        newer_wdata  = NONE_SLOT;
        charge_we    = 1'b0;
        charge_waddr = r_entry[AW-1:0];
        charge_wdata = r_size;
        log_we       = 1'b0;
        log_waddr    = r_cnt[AW-1:0];
        log_wdata    = {r_oldest, ev_freed};

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_cmd     = t_cmd'(i_in_data.cmd);
                    n_entry   = {1'b0, i_in_data.entry};
                    n_size    = SB'(i_in_data.new_size);
                    n_freed   = '0;
                    n_cnt     = '0;
                    n_rel     = 1'b0;
                    n_all     = (t_cmd'(i_in_data.cmd) == CMD_FLUSH);
                    n_protect = NONE_SLOT;
                    n_target  = '0;
                end
            end
            ST_TICK: begin
                n_tick = tick_inc;
                if (tick_due) begin
                    n_next   = r_next + 32'(r_period);
                    n_target = tick_target;
                end
            end
            ST_SET: begin
                n_old     = set_old;
                n_total   = set_total;
                charge_we = 1'b1;
                n_in_list[r_entry[AW-1:0]] = 1'b1;
                if (set_relink) begin
                    if (older_rdata == NONE_SLOT) begin
                        n_oldest = newer_rdata;
                    end else begin
                        newer_we    = 1'b1;
                        newer_waddr = older_rdata[AW-1:0];
                        newer_wdata = newer_rdata;
                    end
                    older_we    = 1'b1;
                    older_waddr = newer_rdata[AW-1:0];
                    older_wdata = older_rdata;
                end
            end
            ST_PUSH1: begin
                older_we    = 1'b1;
                older_wdata = r_newest;
                newer_we    = 1'b1;
                newer_wdata = NONE_SLOT;
                if (r_newest == NONE_SLOT) begin
                    n_oldest = r_entry;
                end
            end
            ST_PUSH2: begin
                if (r_newest != NONE_SLOT) begin
                    newer_we    = 1'b1;
                    newer_waddr = r_newest[AW-1:0];
                    newer_wdata = r_entry;
                end
                n_newest = r_entry;
            end
            ST_CHK: begin
                n_target  = CW'(r_hl3);
                n_protect = r_entry;
            end
            ST_REL: begin
                if (entry_in_list) begin
                    n_freed = charge_rdata;
                    n_total = rel_total;
                    n_rel   = 1'b1;
                    n_in_list[r_entry[AW-1:0]] = 1'b0;
                    if (older_rdata == NONE_SLOT) begin
                        n_oldest = newer_rdata;
                    end else begin
                        newer_we    = 1'b1;
                        newer_waddr = older_rdata[AW-1:0];
                        newer_wdata = newer_rdata;
                    end
                    if (newer_rdata == NONE_SLOT) begin
                        n_newest = older_rdata;
                    end else begin
                        older_we    = 1'b1;
                        older_waddr = newer_rdata[AW-1:0];
                        older_wdata = older_rdata;
                    end
                end
            end
            ST_EV_UPD: begin
                n_freed  = ev_freed;
                n_oldest = newer_rdata;
                n_in_list[r_oldest[AW-1:0]] = 1'b0;
                if (newer_rdata == NONE_SLOT) begin
                    n_newest = NONE_SLOT;
                end else begin
                    older_we    = 1'b1;
                    older_waddr = newer_rdata[AW-1:0];
                    older_wdata = NONE_SLOT;
                end
                log_we = 1'b1;
                n_cnt  = r_cnt + CNT_W'(1);
            end
            ST_EV_END: begin
                n_total = r_all ? '0 : ev_total;
                n_idx   = '0;
            end
            ST_EM_WAIT: begin
                if (out_free) begin
                    n_ov              = 1'b1;
                    n_out.kind        = 1'b0;
                    n_out.victim      = log_rdata[LW-SLOT_W +: 5];
                    n_out.freed_bytes = 32'(log_rdata[SB-1:0]);
                    n_out.total_bytes = 32'(r_total);
                    n_out.released    = 1'b0;
                    n_out.last        = 1'b0;
                    n_idx             = r_idx + CNT_W'(1);
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    n_ov              = 1'b1;
                    n_out.kind        = 1'b1;
                    n_out.victim      = 5'd0;
                    n_out.freed_bytes = 32'(r_freed);
                    n_out.total_bytes = 32'(r_total);
                    n_out.released    = r_rel;
                    n_out.last        = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_oldest  <= NONE_SLOT;
            r_newest  <= NONE_SLOT;
            r_in_list <= '0;
            r_total   <= '0;
            r_tick    <= 32'd0;
            r_next    <= 32'(RST_CLEAN_PERIOD);
            r_ov      <= 1'b0;
            r_ft      <= RST_FREE_TARGET;
            r_hl      <= RST_HIGH_LIMIT;
            r_period  <= RST_CLEAN_PERIOD;
        end else begin
            r_state   <= n_state;
            r_oldest  <= n_oldest;
            r_newest  <= n_newest;
            r_in_list <= n_in_list;
            r_total   <= n_total;
            r_tick    <= n_tick;
            r_next    <= n_next;
            r_ov      <= n_ov;
            if (cfg_wr) begin
                case (t_reg'(paddr[3:2]))
                    REG_FREE_TARGET:  r_ft     <= pwdata;
                    REG_HIGH_LIMIT:   r_hl     <= pwdata;
                    REG_CLEAN_PERIOD: r_period <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_entry   <= n_entry;
        r_size    <= n_size;
        r_old     <= n_old;
        r_freed   <= n_freed;
        r_target  <= n_target;
        r_protect <= n_protect;
        r_all     <= n_all;
        r_rel     <= n_rel;
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_out     <= n_out;
        r_hl3     <= 32'((66'(r_hl) * 66'(RECIP3)) >> RECIP3_SHIFT);
    end
endmodule

// ----- sv/sble_checker.sv -----
`include "size_budget_lru_evictor_top_assert.svh"

module sble_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input sble_pkg::t_out o_out_data,
    input logic           pready
);
    `SBLE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")
    `SBLE_ASSERT_NEXT(a_busy_after_take, i_in_valid && !o_in_stall, o_in_stall, "not busy")
    `SBLE_ASSERT_NOW(a_kind_last, o_out_valid, o_out_data.kind == o_out_data.last, "kind")
    `SBLE_ASSERT_NOW(a_rel_summary, o_out_valid && o_out_data.released, o_out_data.last, "rel")
    `SBLE_ASSERT_NOW(a_pready, 1'b1, pready, "pready low")
endmodule

bind size_budget_lru_evictor_top sble_checker u_sble_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import sble_pkg::*;

    localparam logic [32:0] SIZE_MAX = 33'h0FFFFFFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    size_budget_lru_evictor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic [31:0] free_target_r, high_limit_r;
    logic [15:0] clean_period_r;
    logic [5:0]  older_of [0:31];
    logic [5:0]  newer_of [0:31];
    logic [5:0]  oldest, newest;
    logic [31:0] charge [0:31];
    bit          listed [0:31];
    logic [31:0] total_bytes_r, tick_cnt, next_clean;
    logic [4:0]  evicted_slots [$];
    logic [31:0] evicted_sums [$];

    t_out        expected_results [$];
    int          error_count;
    bit          no_idle;
    int          hold_cycles;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > SIZE_MAX) ? SIZE_MAX[31:0] : s[31:0];
    endfunction

    function automatic void unlink_slot(logic [4:0] s);
        logic [5:0] o, n;
        o = older_of[s];
        n = newer_of[s];
        if (o == NONE_SLOT) oldest = n; else newer_of[o[4:0]] = n;
        if (n == NONE_SLOT) newest = o; else older_of[n[4:0]] = o;
        listed[s] = 0;
    endfunction

    function automatic void push_newest(logic [4:0] s);
        older_of[s] = newest;
        newer_of[s] = NONE_SLOT;
        if (newest == NONE_SLOT) oldest = {1'b0, s};
        else newer_of[newest[4:0]] = {1'b0, s};
        newest = {1'b0, s};
        listed[s] = 1;
    endfunction

    function automatic logic [31:0] evict_oldest(logic [31:0] target, logic [5:0] protect,
                                                 bit all);
        logic [31:0] freed;
        logic [4:0]  v;
        freed = 0;
        while (oldest != NONE_SLOT) begin
            v = oldest[4:0];
            if ({1'b0, v} == protect) break;
            freed = sat_sum(freed, charge[v]);
            charge[v] = 0;
            unlink_slot(v);
            evicted_slots = {evicted_slots, v};
            evicted_sums  = {evicted_sums, freed};
            if (!all && freed >= target) break;
        end
        total_bytes_r = (total_bytes_r > freed) ? total_bytes_r - freed : 0;
        return freed;
    endfunction

    function automatic void reset_predictor();
        free_target_r  = RST_FREE_TARGET;
        high_limit_r   = RST_HIGH_LIMIT;
        clean_period_r = RST_CLEAN_PERIOD;
        for (int i = 0; i < 32; i++) begin
            charge[i] = 0;
            listed[i] = 0;
        end
        oldest        = NONE_SLOT;
        newest        = NONE_SLOT;
        total_bytes_r = 0;
        tick_cnt      = 0;
        next_clean    = {16'd0, RST_CLEAN_PERIOD};
    endfunction

    function automatic void predict_results(t_in x);
        logic [31:0] freed, old, d;
        bit          rel;
        t_out        r;
        freed = 0;
        rel = 0;
        evicted_slots.delete();
        evicted_sums.delete();
        case (t_cmd'(x.cmd))
            CMD_TICK: begin
                tick_cnt = tick_cnt + 1;
                if (tick_cnt >= next_clean) begin
                    if (total_bytes_r > free_target_r) begin
                        d = total_bytes_r - free_target_r;
                        freed = evict_oldest(sat_sum(d, d), NONE_SLOT, 1'b0);
                    end
                    next_clean = next_clean + {16'd0, clean_period_r};
                end
            end
            CMD_SET: begin
                if (x.new_size != 0) begin
                    old = charge[x.entry];
                    if (listed[x.entry]) begin
                        if (newest != {1'b0, x.entry}) begin
                            unlink_slot(x.entry);
                            push_newest(x.entry);
                        end
                    end else begin
                        push_newest(x.entry);
                    end
                    total_bytes_r = (total_bytes_r >= old) ? total_bytes_r - old : 0;
                    total_bytes_r = sat_sum(total_bytes_r, x.new_size);
                    charge[x.entry] = x.new_size;
                    if (x.new_size > old && high_limit_r > 0 && total_bytes_r > high_limit_r)
                        freed = evict_oldest(high_limit_r / 3, {1'b0, x.entry}, 1'b0);
                end
            end
            CMD_REL: begin
                if (listed[x.entry]) begin
                    freed = charge[x.entry];
                    unlink_slot(x.entry);
                    total_bytes_r = (total_bytes_r >= freed) ? total_bytes_r - freed : 0;
                    charge[x.entry] = 0;
                    rel = 1;
                end
            end
            default: begin
                freed = evict_oldest(32'd0, NONE_SLOT, 1'b1);
                total_bytes_r = 0;
            end
        endcase
        foreach (evicted_slots[i]) begin
            r = '0;
            r.victim      = evicted_slots[i];
            r.freed_bytes = evicted_sums[i];
            r.total_bytes = total_bytes_r;
            expected_results = {expected_results, r};
        end
        r = '0;
        r.kind        = 1'b1;
        r.freed_bytes = freed;
        r.total_bytes = total_bytes_r;
        r.released    = rel;
        r.last        = 1'b1;
        expected_results = {expected_results, r};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end

    // receiver idling
    initial begin
        i_out_stall = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_cycles > 0) begin
                i_out_stall <= 1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected transfer", o_out_data.total_bytes, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.kind !== want.kind)
                    report_mismatch("kind", 32'(o_out_data.kind), 32'(want.kind));
                if (o_out_data.victim !== want.victim)
                    report_mismatch("victim", 32'(o_out_data.victim), 32'(want.victim));
                if (o_out_data.freed_bytes !== want.freed_bytes)
                    report_mismatch("freed_bytes", o_out_data.freed_bytes, want.freed_bytes);
                if (o_out_data.total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", o_out_data.total_bytes, want.total_bytes);
                if (o_out_data.released !== want.released)
                    report_mismatch("released", 32'(o_out_data.released), 32'(want.released));
                if (o_out_data.last !== want.last)
                    report_mismatch("last", 32'(o_out_data.last), 32'(want.last));
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [4:0] entry, logic [31:0] new_size);
        t_in x;
        x.cmd      = cmd;
        x.entry    = entry;
        x.new_size = new_size;
        i_in_valid <= 1;
        i_in_data  <= x;
        do @(posedge i_clk); while (o_in_stall);
        predict_results(x);
        if (!no_idle && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg r, logic [31:0] v);
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        case (r)
            REG_FREE_TARGET: free_target_r = v;
            REG_HIGH_LIMIT:  high_limit_r = v;
            default:         clean_period_r = v[15:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] ft, logic [31:0] hl, logic [15:0] period);
        wait_idle();
        write_reg(REG_FREE_TARGET, ft);
        write_reg(REG_HIGH_LIMIT, hl);
        write_reg(REG_CLEAN_PERIOD, {16'd0, period});
    endtask

    task automatic test_set_and_evict();
        configure(32'd500, 32'd1000, 16'd1);
        send_item(CMD_SET, 5'd0, 32'd0);
        send_item(CMD_SET, 5'd31, 32'd400);
        send_item(CMD_SET, 5'd5, 32'd300);
        send_item(CMD_SET, 5'd7, 32'd500);
        send_item(CMD_SET, 5'd5, 32'hFFFF_FFFF);
        send_item(CMD_SET, 5'd5, 32'hFFFF_FFF0);
        send_item(CMD_SET, 5'd5, 32'hFFFF_FFFF);
        send_item(CMD_SET, 5'd9, 32'hFFFF_FFFF);
        send_item(CMD_SET, 5'd3, 32'd10);
        send_item(CMD_SET, 5'd3, 32'd5);
        configure(32'd500, 32'd2, 16'd1);
        send_item(CMD_SET, 5'd1, 32'd5);
        send_item(CMD_SET, 5'd2, 32'd5);
        configure(32'd500, 32'd0, 16'd1);
        send_item(CMD_SET, 5'd4, 32'h8000_0000);
        send_item(CMD_SET, 5'd6, 32'h8000_0000);
    endtask

    task automatic test_release_and_flush();
        send_item(CMD_REL, 5'd4, 32'h1234);
        send_item(CMD_REL, 5'd4, 32'd0);
        send_item(CMD_REL, 5'd30, 32'd0);
        send_item(CMD_FLUSH, 5'd0, 32'd0);
        send_item(CMD_FLUSH, 5'd31, 32'hFFFF_FFFF);
    endtask

    task automatic test_clean_ticks();
        configure(32'd100, 32'hFFFF_FFFF, 16'd1);
        for (int i = 0; i < 8; i++) send_item(CMD_SET, i[4:0], 32'(60 + i));
        for (int i = 0; i < 62; i++) begin
            send_item(CMD_TICK, 5'($urandom), $urandom);
            if (i % 10 == 5) send_item(CMD_SET, 5'($urandom), $urandom_range(50, 400));
        end
    endtask

    task automatic send_random(int count, logic [31:0] scale);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 55)
                send_item(CMD_SET, 5'($urandom),
                          ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, scale));
            else if (k < 72) send_item(CMD_REL, 5'($urandom), $urandom);
            else if (k < 96) send_item(CMD_TICK, 5'($urandom), $urandom);
            else send_item(CMD_FLUSH, 5'($urandom), $urandom);
        end
    endtask

    task automatic test_random_settings();
        configure(32'd300, 32'd2000, 16'd2);
        send_random(10, 32'd700);
        configure(32'd0, 32'd0, 16'd3);
        send_random(8, 32'd1000);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_random(8, 32'hFFFF_FFFF);
        configure($urandom, $urandom, 16'($urandom_range(1, 4)));
        send_random(8, 32'hFFFF_FFFF);
        configure(32'd1000, 32'd5000, 16'd1);
        send_random(10, 32'd2500);
    endtask

    task automatic test_output_hold();
        configure(32'd200, 32'd600, 16'd1);
        hold_cycles = 400;
        no_idle = 1;
        for (int i = 0; i < 8; i++) send_item(CMD_SET, i[4:0], 32'd100);
        send_random(10, 32'd400);
        no_idle = 0;
    endtask

    task automatic test_quiet_tail();
        no_idle = 1;
        send_random(12, 32'd1500);
        send_item(CMD_FLUSH, 5'd0, 32'd0);
    endtask

    initial begin
        error_count = 0;
        no_idle     = 0;
        hold_cycles = 0;
        i_rst_n     = 0;
        i_in_valid  = 0;
        i_in_data   = '0;
        psel        = 0;
        penable     = 0;
        pwrite      = 0;
        paddr       = '0;
        pwdata      = '0;
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_set_and_evict();
        test_release_and_flush();
        test_clean_ticks();
        test_random_settings();
        test_output_hold();
        test_quiet_tail();
        wait_idle();
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/sble_pkg.sv
sv/sble_ram.sv
sv/size_budget_lru_evictor_top.sv
sv/sble_checker.sv
bench/testbench.sv
